// ===== rtl/core/text_console_writer_defines.svh =====
// Assertion macros shared by the console writer RTL.
// The checks are compiled out when SYNTH is defined.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTH
`define TCW_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("console writer check failed");
`define TCW_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("console writer check failed");
`else
`define TCW_ASSERT(label, prop)
`define TCW_ASSERT_IMPL(label, pre, post)
`endif

`endif

// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

    localparam int unsigned COLUMNS_DEF = 80;
    localparam int unsigned ROWS_DEF    = 25;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned COL_W  = 7;
    localparam int unsigned ROW_W  = 5;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned ATTR_W = 8;
    localparam int unsigned CELL_W = CHAR_W + ATTR_W;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_CLEAR,
        S_DONE
    } state_t;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ERR     = 8'h45;
    localparam logic [ATTR_W-1:0] ATTR_ERR     = 8'hF4;
    localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 8'h0F;
    localparam logic [ATTR_W-1:0] ATTR_BLANK   = 8'h00;

endpackage

// ===== rtl/core/tcw_if.sv =====
interface tcw_cmd_if;

    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::OP_W-1:0]      opcode;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::ATTR_W-1:0]    attr;
    logic                          use_cursor;
    logic [tcw_pkg::COL_W-1:0]     col;
    logic [tcw_pkg::ROW_W-1:0]     row;

    modport source (
        output valid, opcode, char_code, attr, use_cursor, col, row,
        input  ready
    );

    modport sink (
        input  valid, opcode, char_code, attr, use_cursor, col, row,
        output ready
    );

endinterface

interface tcw_resp_if;

    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::COL_W-1:0]     cursor_col;
    logic [tcw_pkg::ROW_W-1:0]     cursor_row;
    logic [tcw_pkg::CHAR_W-1:0]    read_char;
    logic [tcw_pkg::ATTR_W-1:0]    read_attr;
    logic                          error;

    modport source (
        output valid, cursor_col, cursor_row, read_char, read_attr, error,
        input  ready
    );

    modport sink (
        input  valid, cursor_col, cursor_row, read_char, read_attr, error,
        output ready
    );

endinterface

// ===== rtl/core/text_console_writer.sv =====
// Channel | Role   | Payload
// cmd     | sink   | opcode, char_code, attr, use_cursor, col, row
// resp    | source | cursor_col, cursor_row, read_char, read_attr, error
//
// A cell read passes S_READ for the registered memory read; writes and backspaces skip it.
// A write that scrolls and a clear sweep the screen memory at one memory cell per cycle.
// After reset the screen memory is swept to zero before cmd is ready.
// The result is held in an output register, so the next item is accepted while it waits;
// a second finished result waits in the block until the first one has been taken.
`include "text_console_writer_defines.svh"

module text_console_writer #(
    parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tcw_cmd_if.sink    cmd,
    tcw_resp_if.source resp
);

    localparam int unsigned CELLS      = COLUMNS * ROWS;
    localparam int unsigned COPY_CELLS = CELLS - COLUMNS;
    localparam int unsigned ADDR_W     = $clog2(CELLS);
    localparam int unsigned COL_W      = tcw_pkg::COL_W;
    localparam int unsigned ROW_W      = tcw_pkg::ROW_W;
    localparam int unsigned CHAR_W     = tcw_pkg::CHAR_W;
    localparam int unsigned ATTR_W     = tcw_pkg::ATTR_W;
    localparam int unsigned CELL_W     = tcw_pkg::CELL_W;

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

    tcw_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ADDR_W-1:0] cur_addr_reg, cur_addr_next;
    logic [CHAR_W-1:0] res_char_reg, res_char_next;
    logic [ATTR_W-1:0] res_attr_reg, res_attr_next;
    logic              res_err_reg, res_err_next;
    logic              wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0] wb_addr_reg, wb_addr_next;
    logic              wb_copy_reg, wb_copy_next;
    logic              out_valid_reg, out_valid_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [ATTR_W-1:0] out_attr_reg, out_attr_next;
    logic              out_err_reg, out_err_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;
    logic              dir_we;
    logic [ADDR_W-1:0] dir_addr;
    logic [CELL_W-1:0] dir_data;

    tcw_pkg::op_t      op;
    logic              off;
    logic [COL_W-1:0]  pos_col;
    logic [ROW_W-1:0]  pos_row;
    logic [ADDR_W-1:0] pos_addr;
    logic [ATTR_W-1:0] wr_attr;
    logic              newline;
    logic              wrap;
    logic              at_home;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign op       = tcw_pkg::op_t'(cmd.opcode);
    assign off      = !cmd.use_cursor
                      && (cmd.col >= COL_W'(COLUMNS) || cmd.row >= ROW_W'(ROWS));
    assign pos_col  = cmd.use_cursor ? cur_col_reg : cmd.col;
    assign pos_row  = cmd.use_cursor ? cur_row_reg : cmd.row;
    assign pos_addr = cmd.use_cursor ? cur_addr_reg
                      : ADDR_W'(ADDR_W'(cmd.row) * ADDR_W'(COLUMNS) + ADDR_W'(cmd.col));
    assign wr_attr  = (cmd.attr == '0) ? tcw_pkg::ATTR_DEFAULT : cmd.attr;
    assign newline  = (cmd.char_code == tcw_pkg::CHAR_NEWLINE);
    assign wrap     = newline || (pos_col == LAST_COL);
    assign at_home  = (cur_col_reg == '0) && (cur_row_reg == '0);

    assign cmd.ready       = (state_reg == tcw_pkg::S_IDLE);
    assign resp.valid      = out_valid_reg;
    assign resp.cursor_col = out_col_reg;
    assign resp.cursor_row = out_row_reg;
    assign resp.read_char  = out_char_reg;
    assign resp.read_attr  = out_attr_reg;
    assign resp.error      = out_err_reg;

    // The scroll copy writes in the cycle after its read, so that write takes priority.
    assign ram_we    = wb_valid_reg || dir_we;
    assign ram_waddr = wb_valid_reg ? wb_addr_reg : dir_addr;
    assign ram_wdata = wb_valid_reg ? (wb_copy_reg ? ram_rdata : '0) : dir_data;

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        cur_addr_next  = cur_addr_reg;
        res_char_next  = res_char_reg;
        res_attr_next  = res_attr_reg;
        res_err_next   = res_err_reg;
        wb_valid_next  = 1'b0;
        wb_addr_next   = wb_addr_reg;
        wb_copy_next   = wb_copy_reg;
        out_valid_next = out_valid_reg && !resp.ready;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_char_next  = out_char_reg;
        out_attr_next  = out_attr_reg;
        out_err_next   = out_err_reg;
        dir_we         = 1'b0;
        dir_addr       = sweep_reg;
        dir_data       = '0;
        ram_re         = 1'b0;
        ram_raddr      = pos_addr;

        unique case (state_reg)
            tcw_pkg::S_INIT:
            begin
                dir_we = 1'b1;
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = tcw_pkg::S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            tcw_pkg::S_IDLE:
            begin
                if (cmd.valid)
                begin
                    res_char_next = '0;
                    res_attr_next = '0;
                    res_err_next  = 1'b0;
                    state_next    = tcw_pkg::S_DONE;
                    unique case (op)
                        tcw_pkg::OP_WRITE:
                        begin
                            if (off)
                            begin
                                dir_we       = 1'b1;
                                dir_addr     = LAST_CELL;
                                dir_data     = {tcw_pkg::ATTR_ERR, tcw_pkg::CHAR_ERR};
                                res_err_next = 1'b1;
                            end
                            else
                            begin
                                dir_we   = !newline;
                                dir_addr = pos_addr;
                                dir_data = {wr_attr, cmd.char_code};
                                if (wrap && pos_row == LAST_ROW)
                                begin
                                    cur_col_next  = '0;
                                    cur_row_next  = LAST_ROW;
                                    cur_addr_next = ADDR_W'(COPY_CELLS);
                                    sweep_next    = '0;
                                    state_next    = tcw_pkg::S_SCROLL;
                                end
                                else if (wrap)
                                begin
                                    cur_col_next  = '0;
                                    cur_row_next  = pos_row + ROW_W'(1);
                                    cur_addr_next = pos_addr - ADDR_W'(pos_col)
                                                    + ADDR_W'(COLUMNS);
                                end
                                else
                                begin
                                    cur_col_next  = pos_col + COL_W'(1);
                                    cur_row_next  = pos_row;
                                    cur_addr_next = pos_addr + ADDR_W'(1);
                                end
                            end
                        end
                        tcw_pkg::OP_BACKSPACE:
                        begin
                            if (!at_home)
                            begin
                                dir_we        = 1'b1;
                                dir_addr      = cur_addr_reg - ADDR_W'(1);
                                dir_data      = {tcw_pkg::ATTR_BLANK, tcw_pkg::CHAR_SPACE};
                                cur_addr_next = cur_addr_reg - ADDR_W'(1);
                                if (cur_col_reg == '0)
                                begin
                                    cur_col_next = LAST_COL;
                                    cur_row_next = cur_row_reg - ROW_W'(1);
                                end
                                else
                                begin
                                    cur_col_next = cur_col_reg - COL_W'(1);
                                end
                            end
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            cur_col_next  = '0;
                            cur_row_next  = '0;
                            cur_addr_next = '0;
                            sweep_next    = '0;
                            state_next    = tcw_pkg::S_CLEAR;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            if (off)
                            begin
                                res_err_next = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = tcw_pkg::S_READ;
                            end
                        end
                    endcase
                end
            end
            tcw_pkg::S_READ:
            begin
                res_char_next = ram_rdata[CHAR_W-1:0];
                res_attr_next = ram_rdata[CELL_W-1:CHAR_W];
                state_next    = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_SCROLL:
            begin
                ram_re        = (sweep_reg < ADDR_W'(COPY_CELLS));
                ram_raddr     = sweep_reg + ADDR_W'(COLUMNS);
                wb_valid_next = 1'b1;
                wb_addr_next  = sweep_reg;
                wb_copy_next  = (sweep_reg < ADDR_W'(COPY_CELLS));
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = tcw_pkg::S_DONE;
                end
                else
                begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            tcw_pkg::S_CLEAR:
            begin
                dir_we   = 1'b1;
                dir_data = {tcw_pkg::ATTR_BLANK, tcw_pkg::CHAR_SPACE};
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = tcw_pkg::S_DONE;
                end
                else
                begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            tcw_pkg::S_DONE:
            begin
                if (!out_valid_reg || resp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = cur_col_reg;
                    out_row_next   = cur_row_reg;
                    out_char_next  = res_char_reg;
                    out_attr_next  = res_attr_reg;
                    out_err_next   = res_err_reg;
                    state_next     = tcw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::S_INIT;
                sweep_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::S_INIT;
            sweep_reg     <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            cur_addr_reg  <= '0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            cur_addr_reg  <= cur_addr_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_char_reg <= res_char_next;
        res_attr_reg <= res_attr_next;
        res_err_reg  <= res_err_next;
        wb_addr_reg  <= wb_addr_next;
        wb_copy_reg  <= wb_copy_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_char_reg <= out_char_next;
        out_attr_reg <= out_attr_next;
        out_err_reg  <= out_err_next;
    end

    `TCW_ASSERT_IMPL(a_wb_no_clash, wb_valid_reg, !dir_we)
    `TCW_ASSERT(a_cursor_on_screen, cur_col_reg <= LAST_COL && cur_row_reg <= LAST_ROW)
    `TCW_ASSERT_IMPL(a_scroll_cursor, state_reg == tcw_pkg::S_SCROLL,
                     cur_col_reg == '0 && cur_row_reg == LAST_ROW)
    `TCW_ASSERT_IMPL(a_clear_cursor, state_reg == tcw_pkg::S_CLEAR,
                     cur_addr_reg == '0 && cur_col_reg == '0 && cur_row_reg == '0)
    `TCW_ASSERT_IMPL(a_err_no_data, out_valid_reg && out_err_reg,
                     out_char_reg == '0 && out_attr_reg == '0)

endmodule

// ===== rtl/core/tcw_ram.sv =====
module tcw_ram #(
    parameter int unsigned WIDTH = tcw_pkg::CELL_W,
    parameter int unsigned DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
